// File: rtl/nfb_pkg.sv
package nfb_pkg;

  localparam int unsigned NfbEntriesDefault = 3;

  localparam int unsigned AddrW   = 16;
  localparam int unsigned TicksW  = 16;
  localparam int unsigned CountW  = 8;
  localparam int unsigned StatusW = 3;

  localparam logic [CountW-1:0] CountMax = '1;

  localparam logic [TicksW-1:0] TimeoutReset   = 16'd1280;
  localparam logic [CountW-1:0] ThresholdReset = 8'd3;

  // request kinds carried on tuser
  typedef enum logic {
    REQ_REPORT = 1'b0,
    REQ_DELETE = 1'b1
  } nfb_req_e;

  typedef enum logic [StatusW-1:0] {
    ST_UPDATED  = 3'd0,
    ST_NEW      = 3'd1,
    ST_FULL     = 3'd2,
    ST_DELETED  = 3'd3,
    ST_DEL_MISS = 3'd4
  } nfb_status_e;

  // register index = paddr[2]
  typedef enum logic {
    REG_TIMEOUT   = 1'b0,
    REG_THRESHOLD = 1'b1
  } nfb_reg_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_CMP,
    S_UPD,
    S_MISS,
    S_DONE
  } nfb_state_e;

  typedef struct packed {
    logic [TicksW-1:0] stamp;
    logic [CountW-1:0] count;
    logic [AddrW-1:0]  addr;
  } nfb_entry_t;

  typedef struct packed {
    logic              match;
    logic              aged;
    logic [CountW-1:0] count_next;
    logic              black;
  } nfb_alu_t;

endpackage

// File: rtl/nfb_alu.sv
// Per-entry evaluation unit, reused for every slot during the scan.
module nfb_alu
  import nfb_pkg::*;
(
  input  logic [AddrW-1:0]  key_addr_i,
  input  logic [TicksW-1:0] now_i,
  input  nfb_entry_t        entry_i,
  input  logic [TicksW-1:0] timeout_i,
  input  logic [CountW-1:0] threshold_i,
  output nfb_alu_t          res_o
);

  logic [TicksW-1:0] age;
  logic [CountW-1:0] base;

  always_comb begin
    age            = now_i - entry_i.stamp;  // wraps mod 2^16
    res_o.match    = (entry_i.addr == key_addr_i);
    res_o.aged     = (age > timeout_i);
    base           = res_o.aged ? '0 : entry_i.count;
    res_o.count_next = (base == CountMax) ? CountMax : base + CountW'(1);
    res_o.black    = (res_o.count_next > threshold_i);
  end

endmodule

// File: rtl/neighbour_failure_blacklist.sv
// Channel   | Dir | Payload                                    | Handshake
// s_axis    | in  | tuser: req_type; tdata: neighbour_addr,    | tvalid/tready
//           |     |   now_ticks (low to high)                  |
// m_axis    | out | tdata: blacklisted, status, zero pad       | tvalid/tready
// apb       | in  | timeout_ticks @0x0, fail_threshold @0x4    | psel/penable
//
// Scan: a request scans k slots, k being in 1..TABLE_ENTRIES; the shared
//   per-slot unit and the single read port of the slot memory take the slots
//   in turn, each slot read (S_READ), then compared (S_CMP).
// Reset: valid flags clear at once, registers load defaults; no clearing pass.
// Stalls: the result sits in the output register; the next request is taken
//   while it waits, but finishing that request waits for the register to free.
module neighbour_failure_blacklist
  import nfb_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = NfbEntriesDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // request stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [15:0] neighbour_addr, [31:16] now_ticks
  input  logic        s_axis_tuser,   // [0] req_type
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [0] blacklisted, [3:1] status, [7:4] zero
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned IdxW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(TABLE_ENTRIES - 1);

  // ---------------- configuration ----------------
  logic [TicksW-1:0] timeout_q;
  logic [CountW-1:0] threshold_q;
  logic              cfg_wr;
  nfb_reg_e          reg_sel;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign reg_sel = nfb_reg_e'(paddr[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q   <= TimeoutReset;
      threshold_q <= ThresholdReset;
    end else if (cfg_wr) begin
      case (reg_sel)
        REG_TIMEOUT:   timeout_q   <= pwdata[TicksW-1:0];
        REG_THRESHOLD: threshold_q <= pwdata[CountW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_TIMEOUT:   prdata = {{(32-TicksW){1'b0}}, timeout_q};
      REG_THRESHOLD: prdata = {{(32-CountW){1'b0}}, threshold_q};
      default:       prdata = '0;
    endcase
  end

  // ---------------- request capture ----------------
  nfb_state_e        state_q, state_d;
  nfb_req_e          req_q;
  logic [AddrW-1:0]  key_q;
  logic [TicksW-1:0] now_q;
  logic              in_acc;

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_acc        = s_axis_tvalid & s_axis_tready;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      req_q <= nfb_req_e'(s_axis_tuser);
      key_q <= s_axis_tdata[AddrW-1:0];
      now_q <= s_axis_tdata[AddrW+TicksW-1:AddrW];
    end
  end

  // ---------------- slot store ----------------
  // valid flags in flops; address/count/stamp in a memory with one read and one write port
  logic [TABLE_ENTRIES-1:0] valid_q, valid_d;
  nfb_entry_t               mem_q [TABLE_ENTRIES];
  nfb_entry_t               rd_q;
  logic                     wr_en;
  logic [IdxW-1:0]          wr_idx;
  nfb_entry_t               wr_data;
  logic [IdxW-1:0]          idx_q, idx_d;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_idx] <= wr_data;
    end
    rd_q <= mem_q[idx_q];
  end

  // shared per-slot unit
  nfb_alu_t alu;

  nfb_alu u_alu (
    .key_addr_i  (key_q),
    .now_i       (now_q),
    .entry_i     (rd_q),
    .timeout_i   (timeout_q),
    .threshold_i (threshold_q),
    .res_o       (alu)
  );

  // ---------------- sequencer ----------------
  logic            free_found_q, free_found_d;
  logic [IdxW-1:0] free_idx_q, free_idx_d;
  nfb_status_e     res_status_q, res_status_d;
  logic            res_black_q, res_black_d;
  logic            out_load;
  logic            m_valid_q;
  logic [7:0]      m_data_q;

  always_comb begin
    state_d      = state_q;
    idx_d        = idx_q;
    valid_d      = valid_q;
    free_found_d = free_found_q;
    free_idx_d   = free_idx_q;
    res_status_d = res_status_q;
    res_black_d  = res_black_q;
    wr_en        = 1'b0;
    wr_idx       = idx_q;
    wr_data      = '{stamp: now_q, count: alu.count_next, addr: key_q};
    out_load     = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          idx_d        = '0;
          free_found_d = 1'b0;
          free_idx_d   = '0;
          state_d      = S_READ;
        end
      end
      S_READ: begin
        state_d = S_CMP;  // memory read of slot idx in flight
      end
      S_CMP: begin
        if (!valid_q[idx_q] && !free_found_q) begin
          free_found_d = 1'b1;
          free_idx_d   = idx_q;
        end
        if (valid_q[idx_q] && alu.match) begin
          state_d = S_UPD;
        end else if (idx_q == LastIdx) begin
          state_d = S_MISS;
        end else begin
          idx_d   = idx_q + IdxW'(1);
          state_d = S_READ;
        end
      end
      S_UPD: begin
        if (req_q == REQ_DELETE) begin
          valid_d[idx_q] = 1'b0;
          res_status_d   = ST_DELETED;
          res_black_d    = 1'b0;
        end else begin
          wr_en        = 1'b1;
          res_status_d = ST_UPDATED;
          res_black_d  = alu.black;
        end
        state_d = S_DONE;
      end
      S_MISS: begin
        res_black_d = 1'b0;
        if (req_q == REQ_DELETE) begin
          res_status_d = ST_DEL_MISS;
        end else if (free_found_q) begin
          wr_en               = 1'b1;
          wr_idx              = free_idx_q;
          wr_data.count       = CountW'(1);
          valid_d[free_idx_q] = 1'b1;
          res_status_d        = ST_NEW;
        end else begin
          res_status_d = ST_FULL;
        end
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!m_valid_q || m_axis_tready) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      valid_q      <= '0;
      idx_q        <= '0;
      free_found_q <= 1'b0;
      free_idx_q   <= '0;
      res_status_q <= ST_UPDATED;
      res_black_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      valid_q      <= valid_d;
      idx_q        <= idx_d;
      free_found_q <= free_found_d;
      free_idx_q   <= free_idx_d;
      res_status_q <= res_status_d;
      res_black_q  <= res_black_d;
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (out_load) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      m_data_q <= {4'b0000, res_status_q, res_black_q};
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

`ifndef NO_ASSERTIONS
  // a fresh result only appears out of the finishing state
  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load |-> state_q == S_DONE))
    else $error("result loaded outside finishing state");

  // a new entry adds exactly one valid slot
  a_new_adds_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MISS && req_q == REQ_REPORT && free_found_q) |=>
      ($countones(valid_q) == $past($countones(valid_q)) + 1))
    else $error("new entry did not claim exactly one slot");

  // a delete hit frees the slot it matched
  a_delete_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_UPD && req_q == REQ_DELETE) |=> !valid_q[$past(idx_q)])
    else $error("deleted slot still valid");

  // scan index never leaves the table
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (idx_q <= LastIdx))
    else $error("scan index out of range");
`endif

endmodule
